FILE: hdl/fnid_pkg.sv
package fnid_pkg;

	localparam int unsigned MAX_NAME_BYTES_DEF = 256;
	localparam int unsigned QUEUE_DEPTH_DEF    = 4;

	localparam logic [31:0] PAD_WORD_A = 32'h9BE74448;
	localparam logic [31:0] PAD_WORD_B = 32'h66F42C48;
	localparam logic [31:0] INIT_V     = 32'hF4FA8928;
	localparam logic [31:0] INIT_X     = 32'h37A8470E;
	localparam logic [31:0] INIT_Y     = 32'h7758B42B;
	localparam logic [31:0] KEY_W      = 32'h267B0B11;
	localparam logic [31:0] OR_A       = 32'h02040801;
	localparam logic [31:0] AND_C      = 32'hBFEF7FDF;
	localparam logic [31:0] OR_B       = 32'h00804021;
	localparam logic [31:0] AND_D      = 32'h7DFEFBFF;

	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_SLASH  = 8'h2F;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// One request from the front to the round engine
	typedef struct packed {
		logic        fin;      // name ends: run pad rounds and emit
		logic        do_word;  // run a round on word
		logic [31:0] word;
	} queue_entry_t;

endpackage

FILE: hdl/fnid_front.sv
module fnid_front import fnid_pkg::*; #(
	parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] char_byte
	input  logic         s_tuser,   // [0] has_byte
	input  logic         s_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data,
	output logic         push,
	output queue_entry_t push_data,
	input  logic         full
);

	localparam int unsigned CNT_W = $clog2(MAX_NAME_BYTES + 1);

	logic             normalize_mode_q;
	logic [31:0]      word_accum_q;
	logic [1:0]       byte_slot_q;
	logic [CNT_W-1:0] bytes_taken_q;
	logic             name_ended_q;

	logic             accept;
	logic             take;
	logic [7:0]       c_norm;
	logic [31:0]      accum_next;
	logic [1:0]       slot_next;
	logic             word_done;

	assign s_tready  = !full;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	// Normalize and pack the incoming byte
	always_comb begin
		c_norm = s_tdata;
		if (normalize_mode_q) begin
			if (s_tdata inside {[8'h41:8'h5A]})
				c_norm = s_tdata + CASE_OFFSET;
			else if (s_tdata == CHAR_BSLASH)
				c_norm = CHAR_SLASH;
		end
		take = s_tuser && !name_ended_q && (s_tdata != 8'h00)
			&& (bytes_taken_q < CNT_W'(MAX_NAME_BYTES));
		accum_next = word_accum_q;
		slot_next  = byte_slot_q;
		if (take) begin
			accum_next = word_accum_q | ({24'b0, c_norm} << {byte_slot_q, 3'b000});
			slot_next  = byte_slot_q + 2'd1;
		end
		word_done = take && (byte_slot_q == 2'd3);
	end

	// Request a round on a full word, or the close of a name
	assign push              = accept && (word_done || s_tlast);
	assign push_data.fin     = s_tlast;
	assign push_data.do_word = word_done || (s_tlast && (slot_next != 2'd0));
	assign push_data.word    = accum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normalize_mode_q <= 1'b1;
			word_accum_q     <= '0;
			byte_slot_q      <= '0;
			bytes_taken_q    <= '0;
			name_ended_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				normalize_mode_q <= cfg_data;
			if (accept) begin
				if (s_tlast) begin
					word_accum_q  <= '0;
					byte_slot_q   <= '0;
					bytes_taken_q <= '0;
					name_ended_q  <= 1'b0;
				end else begin
					word_accum_q <= word_done ? 32'h0 : accum_next;
					byte_slot_q  <= slot_next;
					if (take)
						bytes_taken_q <= bytes_taken_q + CNT_W'(1);
					if (s_tuser && (s_tdata == 8'h00))
						name_ended_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hdl/fnid_queue.sv
module fnid_queue import fnid_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t push_data,
	output logic         full,
	input  logic         pop,
	output queue_entry_t pop_data,
	output logic         empty
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	queue_entry_t     entries [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries[rd_ptr_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (push)
			entries[wr_ptr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + IDX_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

FILE: hdl/fnid_core.sv
module fnid_core import fnid_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	output logic         pop,
	input  queue_entry_t pop_data,
	input  logic         empty,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata    // [31:0] name_id
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL1,
		ST_MUL2,
		ST_FOLD,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [31:0] hash_x_q;
	logic [31:0] hash_y_q;
	logic [31:0] rot_v_q;
	logic [31:0] word_q;
	logic [1:0]  pads_q;
	logic        fin_q;
	logic [31:0] x_s1, y_s1, m1_s1, m2_s1;
	logic [63:0] prod_q;
	logic [31:0] nx_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic [31:0] v_rot, k, x_w, y_w;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [32:0] s1, s2;
	logic [31:0] nx, ny;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Round setup: rotate, key and mask the multiplier operands
	always_comb begin
		v_rot = {rot_v_q[30:0], rot_v_q[31]};
		k     = KEY_W ^ v_rot;
		x_w   = hash_x_q ^ word_q;
		y_w   = hash_y_q ^ word_q;
	end

	// Shared multiplier
	assign mul_a = (state_q == ST_MUL1) ? x_s1 : y_s1;
	assign mul_b = (state_q == ST_MUL1) ? m1_s1 : m2_s1;
	assign mul_p = mul_a * mul_b;

	// Fold high halves back into low halves
	always_comb begin
		s1 = {1'b0, prod_q[31:0]} + {1'b0, prod_q[63:32]}
			+ {32'b0, (prod_q[63:32] != 32'h0)};
		nx = s1[31:0] + {31'b0, s1[32]};
		s2 = {1'b0, prod_q[31:0]} + {1'b0, prod_q[62:32], 1'b0} + {32'b0, prod_q[63]};
		ny = s2[31:0] + (s2[32] ? 32'd2 : 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hash_x_q    <= INIT_X;
			hash_y_q    <= INIT_Y;
			rot_v_q     <= INIT_V;
			word_q      <= '0;
			pads_q      <= '0;
			fin_q       <= 1'b0;
			x_s1        <= '0;
			y_s1        <= '0;
			m1_s1       <= '0;
			m2_s1       <= '0;
			prod_q      <= '0;
			nx_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// Drop the result once taken; the emit state reloads it on its own
			if (m_tready && (state_q != ST_EMIT))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						fin_q <= pop_data.fin;
						if (pop_data.do_word) begin
							word_q <= pop_data.word;
							pads_q <= pop_data.fin ? 2'd2 : 2'd0;
						end else begin
							word_q <= PAD_WORD_A;
							pads_q <= 2'd1;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					rot_v_q <= v_rot;
					x_s1    <= x_w;
					y_s1    <= y_w;
					m1_s1   <= ((k + y_w) | OR_A) & AND_C;
					m2_s1   <= ((k + x_w) | OR_B) & AND_D;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					prod_q  <= mul_p;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					nx_q    <= nx;
					prod_q  <= mul_p;
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					hash_x_q <= nx_q;
					hash_y_q <= ny;
					if (pads_q != 2'd0) begin
						word_q  <= (pads_q == 2'd2) ? PAD_WORD_A : PAD_WORD_B;
						pads_q  <= pads_q - 2'd1;
						state_q <= ST_PREP;
					end else if (fin_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					// Hold until the output register is free
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= hash_x_q ^ hash_y_q;
						hash_x_q    <= INIT_X;
						hash_y_q    <= INIT_Y;
						rot_v_q     <= INIT_V;
						fin_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_emit_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_valid_q && !m_tready) |=> (state_q == ST_EMIT))
		else $error("result overwritten before taken");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_PREP)) else $error("pop did not start a round");
	a_pads_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(pads_q != 2'd0) |-> fin_q) else $error("pad rounds without name end");

endmodule

FILE: hdl/filename_id_hash.sv
// Flow: with the engine idle a closing item is popped from the queue and runs two or
//   three rounds, each a setup, two products on the one shared 32x32 multiplier and a
//   fold; the result is then registered for output.
// Throughput: one input item per cycle while the four-entry queue has room; the
//   round engine finishes each queued request, pad rounds included, before it pops the next.
// Reset: arst_n resets all state but the queue storage at once; normalize_mode resets to 1.
module filename_id_hash import fnid_pkg::*; #(
	parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF,
	parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tuser,   // [0] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] name_id
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic         push;
	logic         pop;
	logic         full;
	logic         empty;
	queue_entry_t push_data;
	queue_entry_t pop_data;

	fnid_front #(
		.MAX_NAME_BYTES(MAX_NAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	fnid_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	fnid_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fnid_pkg::*;

	typedef enum int {KIND_CLEAN, KIND_NOISE, KIND_LONG} name_kind_t;
	typedef enum int {END_ON_BYTE, END_MARKER, END_ZERO} name_end_t;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam int unsigned SETTLE_CYCLES = 40;

	// Tracks the hash of the name in flight and the ids still owed by the block
	class name_id_tracker;
		logic [31:0] word_buf;
		logic [1:0]  slot_idx;
		int unsigned byte_count;
		logic [31:0] hx;
		logic [31:0] hy;
		logic [31:0] rv;
		bit          zero_seen;
		bit          lower_case;
		logic [31:0] pending_ids[$];
		int unsigned errors;
		int unsigned useful;

		function new();
			lower_case = 1'b1;
			errors = 0;
			useful = 0;
			restart_name();
		endfunction

		function void restart_name();
			word_buf = '0;
			slot_idx = '0;
			byte_count = 0;
			hx = INIT_X;
			hy = INIT_Y;
			rv = INIT_V;
			zero_seen = 1'b0;
		endfunction

		// Mix one word: two masked products, each folded back with carries
		function void hash_round(logic [31:0] w);
			logic [31:0] k, x, y, m1, m2, lo, hi, nx, ny;
			logic [63:0] p, s;
			rv = {rv[30:0], rv[31]};
			k = KEY_W ^ rv;
			x = hx ^ w;
			y = hy ^ w;
			m1 = ((k + y) | OR_A) & AND_C;
			p = {32'd0, x} * {32'd0, m1};
			lo = p[31:0];
			hi = p[63:32];
			s = {32'd0, lo} + {32'd0, hi} + ((hi != 32'd0) ? 64'd1 : 64'd0);
			nx = s[31:0] + s[63:32];
			m2 = ((k + x) | OR_B) & AND_D;
			p = {32'd0, y} * {32'd0, m2};
			lo = p[31:0];
			hi = p[63:32];
			s = {32'd0, lo} + {32'd0, hi[30:0], 1'b0} + {63'd0, hi[31]};
			ny = s[31:0];
			if (s[63:32] != 32'd0) begin
				ny = ny + 32'd2;
			end
			hx = nx;
			hy = ny;
		endfunction

		// Note one accepted request; queue the id when it closes the name
		function void take_item(logic [7:0] c, logic has, logic fin);
			logic [7:0] b;
			bit mattered;
			b = c;
			mattered = fin;
			if (has && !zero_seen) begin
				if (b == CHAR_NUL) begin
					zero_seen = 1'b1;
					mattered = 1'b1;
				end else if (byte_count < MAX_NAME_BYTES_DEF) begin
					if (lower_case) begin
						if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
							b = b + CASE_OFFSET;
						else if (b == CHAR_BSLASH)
							b = CHAR_SLASH;
					end
					word_buf = word_buf | ({24'd0, b} << (8 * slot_idx));
					byte_count++;
					slot_idx++;
					mattered = 1'b1;
					if (slot_idx == 2'd0) begin
						hash_round(word_buf);
						word_buf = '0;
					end
				end
			end
			if (mattered)
				useful++;
			if (fin) begin
				if (slot_idx != 2'd0)
					hash_round(word_buf);
				hash_round(PAD_WORD_A);
				hash_round(PAD_WORD_B);
				pending_ids.push_back(hx ^ hy);
				restart_name();
			end
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		// Compare one returned id with the oldest one owed
		task check_id(logic [31:0] got);
			logic [31:0] want;
			if (pending_ids.size() == 0) begin
				report($sformatf("name_id %08h with none owed", got));
			end else begin
				want = pending_ids.pop_front();
				if (got !== want)
					report($sformatf("name_id got %08h want %08h", got, want));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_byte
	logic        s_tuser;   // [0] has_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] name_id
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	name_id_tracker tracker = new();
	bit          tx_steady;
	bit          rx_steady;
	int unsigned rx_hold;

	filename_id_hash DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop for a hung run
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Drive the result ready, holding off for the drawn stall
	initial begin
		m_tready = 1'b0;
		rx_hold = 0;
		rx_steady = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check each returned id and draw the next stall
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_id(m_tdata);
			rx_hold = rx_steady ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 15) == 0)
				rx_steady = !rx_steady;
		end
	end

	// Send one request after a drawn gap; return at the next falling edge
	task automatic send_item(input logic [7:0] c, input logic has, input logic fin);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= has;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.take_item(c, has, fin);
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed id, then let the engine go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending_ids.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.lower_case = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly file-name characters, with case and separators to normalize
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 5))
			0: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
			1: return CHAR_LOWER_A + 8'($urandom_range(0, 25));
			2: return CHAR_DIGIT_0 + 8'($urandom_range(0, 9));
			3: return CHAR_BSLASH;
			4: return $urandom_range(0, 1) ? CHAR_SLASH : CHAR_DOT;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic send_name(input name_kind_t kind);
		int unsigned len;
		name_end_t how;
		logic fin;
		tx_steady = ($urandom_range(0, 3) == 0);
		case (kind)
			KIND_CLEAN: begin
				len = $urandom_range(0, 12);
				how = name_end_t'($urandom_range(0, 2));
				if (len == 0 && how == END_ON_BYTE)
					how = END_MARKER;
				for (int i = 0; i < len; i++)
					send_item(pick_char(), 1'b1, how == END_ON_BYTE && i == len - 1);
				if (how == END_MARKER) begin
					send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				end else if (how == END_ZERO) begin
					fin = $urandom_range(0, 1);
					send_item(CHAR_NUL, 1'b1, fin);
					if (!fin) begin
						repeat ($urandom_range(0, 3))
							send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
								1'b0);
						send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
					end
				end
			end
			KIND_NOISE: begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						i == len - 1);
			end
			default: begin
				len = $urandom_range(250, 300);
				for (int i = 0; i < len; i++)
					send_item(pick_char(), 1'b1, i == len - 1);
			end
		endcase
	endtask

	initial begin
		int unsigned phase_goal;
		int unsigned r;
		logic phase_mode;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		arst_n = 1'b0;
		tx_steady = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_mode(1'b1);

		// Empty name: marker only, byte field ignored
		send_item(8'hAA, 1'b0, 1'b1);
		// Case folding, backslash, top byte, close on a byte
		send_item(CHAR_UPPER_A, 1'b1, 1'b0);
		send_item(CHAR_UPPER_Z, 1'b1, 1'b0);
		send_item(CHAR_BSLASH, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);
		// Skip a byteless request, then ignore everything after a zero
		send_item(CHAR_LOWER_A, 1'b1, 1'b0);
		send_item(CHAR_UPPER_A, 1'b0, 1'b0);
		send_item(CHAR_NUL, 1'b1, 1'b0);
		send_item(8'h42, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b1);
		// Zero byte that also closes the name
		send_item(8'h78, 1'b1, 1'b0);
		send_item(CHAR_NUL, 1'b1, 1'b1);
		// Switch normalization off partway through a name
		send_item(8'h51, 1'b1, 1'b0);
		send_item(CHAR_BSLASH, 1'b1, 1'b0);
		settle();
		write_mode(1'b0);
		send_item(8'h51, 1'b1, 1'b0);
		send_item(CHAR_BSLASH, 1'b1, 1'b0);
		send_item(8'h6D, 1'b1, 1'b1);
		// Raw bytes with normalization off
		send_item(CHAR_UPPER_A, 1'b1, 1'b0);
		send_item(CHAR_BSLASH, 1'b1, 1'b1);

		// Random phases: normalization off, then on, then drawn at random
		for (int ph = 0; ph < 4; ph++) begin
			phase_mode = (ph < 2) ? (ph == 1) : 1'($urandom_range(0, 1));
			settle();
			write_mode(phase_mode);
			phase_goal = tracker.useful + 110;
			if (ph == 0)
				send_name(KIND_LONG);
			while (tracker.useful < phase_goal) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					send_name(KIND_NOISE);
				else
					send_name(KIND_CLEAN);
				if ($urandom_range(0, 24) == 0)
					settle();
			end
		end

		settle();
		if (tracker.errors == 0 && tracker.pending_ids.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
